/* rtl/u2l_pkg.sv */
// Shared types, register indexes and glyph tables for the UTF-8 to LCD code mapper.
package u2l_pkg;

  // Configuration register indexes
  localparam logic REG_MISSING_CODE = 1'b0;
  localparam logic REG_INVALID_CODE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] MISSING_RESET = 8'h20;
  localparam logic [7:0] INVALID_RESET = 8'hFF;

  // Byte classes
  localparam logic [7:0] ASCII_FIRST   = 8'h20;
  localparam logic [7:0] ASCII_LAST    = 8'h7D;
  localparam logic [7:0] BACKSLASH     = 8'h5C;
  localparam logic [7:0] LEAD2_FIRST   = 8'hC2;
  localparam logic [7:0] LEAD2_LAST    = 8'hDF;
  localparam logic [7:0] LEAD3_FIRST   = 8'hE0;
  localparam logic [7:0] LEAD3_LAST    = 8'hEF;
  localparam logic [7:0] LEAD4_FIRST   = 8'hF0;
  localparam logic [7:0] LEAD4_LAST    = 8'hF4;

  // Table lookup result: hit flag and glyph code
  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } map_t;

  // One result from the decoder towards the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       is_end;
  } result_t;

  // Two-byte sequences
  function automatic map_t map_two(input logic [7:0] lead, input logic [7:0] c1);
    map_t m;
    m.hit  = 1'b1;
    m.code = 8'h00;
    case ({lead, c1})
      16'hC2A0: m.code = 8'h20;
      16'hC2A2: m.code = 8'hEC;
      16'hC2A5: m.code = 8'h5C;
      16'hC2B0: m.code = 8'hDF;
      16'hC2B5: m.code = 8'hE4;
      16'hC2B7: m.code = 8'hA5;
      16'hC3A4: m.code = 8'hE1;
      16'hC3B1: m.code = 8'hEE;
      16'hC3B6: m.code = 8'hEF;
      16'hC3B7: m.code = 8'hFD;
      16'hC3BC: m.code = 8'hF5;
      16'hCEA3: m.code = 8'hF6;
      16'hCEA9: m.code = 8'hF4;
      16'hCEB1: m.code = 8'hE0;
      16'hCEB2: m.code = 8'hE2;
      16'hCEB4: m.code = 8'hE5;
      16'hCEB5: m.code = 8'hE3;
      16'hCEB8: m.code = 8'hF2;
      16'hCEBC: m.code = 8'hE4;
      16'hCF80: m.code = 8'hF7;
      16'hCF81: m.code = 8'hE6;
      default:  m.hit  = 1'b0;
    endcase
    return m;
  endfunction

  // Three-byte sequences
  function automatic map_t map_three(input logic [7:0] lead, input logic [7:0] c1,
                                     input logic [7:0] c2);
    map_t m;
    m.hit  = 1'b1;
    m.code = 8'h00;
    case ({lead, c1, c2})
      24'hE282A4: m.code = 8'hED;
      24'hE28690: m.code = 8'h7F;
      24'hE28692: m.code = 8'h7E;
      24'hE28891: m.code = 8'hF6;
      24'hE2889A: m.code = 8'hE8;
      24'hE2889E: m.code = 8'hF3;
      24'hE28C9C: m.code = 8'hA2;
      24'hE28C9F: m.code = 8'hA3;
      24'hE29688: m.code = 8'hFF;
      default:    m.hit  = 1'b0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/utf8_to_lcd_charset_map.sv */
// Top level of the UTF-8 to LCD character-ROM code mapper.
//
// Usage: UTF-8 text enters one byte per item on the s_ channel (s_tdata).
// Each complete character leaves as one item on the m_ channel: m_tdata
// carries the ROM code and m_tlast marks a string terminator (NUL outside a
// multibyte sequence, code 0). Lead bytes and inner continuation bytes give
// no output item; the last byte of a sequence gives its code.
// Two configuration registers are written through cfg_we/cfg_index/cfg_data:
// index 0 is the code for bytes with no glyph, index 1 the code for unmapped
// multibyte sequences. Write them only while the block is idle.
// The accepted byte lands in the input register, and a decode step then
// writes its result into the result register once that register can take it.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode step between the two registers.
// Reset (rst, synchronous) empties both registers, clears the sequence
// state and restores codes 0x20 and 0xFF. When the receiver stalls the
// result register holds; one more byte is taken into the input register
// and s_tready then falls until the result is taken.
module utf8_to_lcd_charset_map (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] char_code
  output logic       m_tlast,    // is_end
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] missing_code;
  logic [7:0] invalid_code;
  logic       can_take;
  logic       step;
  u2l_pkg::result_t res;

  assign step     = s1_valid && can_take;
  assign s_tready = !s1_valid || can_take;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_code <= u2l_pkg::MISSING_RESET;
      invalid_code <= u2l_pkg::INVALID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        u2l_pkg::REG_MISSING_CODE: missing_code <= cfg_data;
        u2l_pkg::REG_INVALID_CODE: invalid_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: take a byte or drop it once decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
    end
  end

  u2l_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (s1_byte),
    .missing_code (missing_code),
    .invalid_code (invalid_code),
    .res          (res)
  );

  u2l_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .res      (res),
    .can_take (can_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // A terminator always carries code zero
  a_end_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
    else $error("terminator item with non-zero code");

  // A byte waiting on a stalled result register is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !can_take) |=> (s1_valid && $stable(s1_byte)))
    else $error("input register lost a byte under stall");

  // An empty input register always takes a byte
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input register empty but not ready");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");
`endif

endmodule

/* rtl/u2l_decode.sv */
// Sequence state and per-byte decode of the UTF-8 stream into glyph codes.
module u2l_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  input  logic [7:0]           missing_code,
  input  logic [7:0]           invalid_code,
  output u2l_pkg::result_t     res
);

  logic [1:0] bytes_left, bytes_left_next;
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [1:0] left_dec;
  u2l_pkg::map_t m2, m3;

  assign left_dec = bytes_left - 2'd1;
  assign m2 = u2l_pkg::map_two(lead_byte, in_byte);
  assign m3 = u2l_pkg::map_three(lead_byte, second_byte, in_byte);

  // Decode one byte against the current sequence state
  always_comb begin
    bytes_left_next  = bytes_left;
    lead_byte_next   = lead_byte;
    second_byte_next = second_byte;
    res.valid        = 1'b1;
    res.code         = missing_code;
    res.is_end       = 1'b0;
    if (bytes_left != 2'd0) begin
      if (bytes_left == 2'd2) begin
        second_byte_next = in_byte;
      end
      bytes_left_next = left_dec;
      if (left_dec != 2'd0) begin
        res.valid = 1'b0;
      end else if (lead_byte >= u2l_pkg::LEAD2_FIRST && lead_byte <= u2l_pkg::LEAD2_LAST) begin
        res.code = m2.hit ? m2.code : invalid_code;
      end else if (lead_byte >= u2l_pkg::LEAD3_FIRST && lead_byte <= u2l_pkg::LEAD3_LAST) begin
        res.code = m3.hit ? m3.code : invalid_code;
      end else begin
        res.code = invalid_code;
      end
    end else if (in_byte == 8'h00) begin
      res.code   = 8'h00;
      res.is_end = 1'b1;
    end else if (in_byte < u2l_pkg::ASCII_FIRST) begin
      res.code = missing_code;
    end else if (in_byte <= u2l_pkg::ASCII_LAST) begin
      res.code = (in_byte == u2l_pkg::BACKSLASH) ? missing_code : in_byte;
    end else if (in_byte >= u2l_pkg::LEAD2_FIRST && in_byte <= u2l_pkg::LEAD2_LAST) begin
      lead_byte_next  = in_byte;
      bytes_left_next = 2'd1;
      res.valid       = 1'b0;
    end else if (in_byte >= u2l_pkg::LEAD3_FIRST && in_byte <= u2l_pkg::LEAD3_LAST) begin
      lead_byte_next  = in_byte;
      bytes_left_next = 2'd2;
      res.valid       = 1'b0;
    end else if (in_byte >= u2l_pkg::LEAD4_FIRST && in_byte <= u2l_pkg::LEAD4_LAST) begin
      lead_byte_next  = in_byte;
      bytes_left_next = 2'd3;
      res.valid       = 1'b0;
    end else begin
      res.code = missing_code;
    end
  end

  // Advance the sequence state once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= 2'd0;
      lead_byte   <= 8'h00;
      second_byte <= 8'h00;
    end else if (step) begin
      bytes_left  <= bytes_left_next;
      lead_byte   <= lead_byte_next;
      second_byte <= second_byte_next;
    end
  end

endmodule

/* rtl/u2l_out_reg.sv */
// Result register on the master side of the stream.
module u2l_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  u2l_pkg::result_t     res,
  output logic                 can_take,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] char_code
  output logic                 m_tlast    // is_end
);

  logic       out_valid;
  logic [7:0] out_code;
  logic       out_end;

  assign can_take = !out_valid || m_tready;

  // Load a new result or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload until it is taken
  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_code <= res.code;
      out_end  <= res.is_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_code;
  assign m_tlast  = out_end;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the UTF-8 to LCD character-ROM code mapper.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  // One expected display code
  typedef struct {
    logic [7:0] code;
    logic       is_end;
  } glyph_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;     // [7:0] in_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;             // [7:0] char_code
  logic       m_tlast;             // is_end
  logic       cfg_we = 1'b0;
  logic       cfg_index = u2l_pkg::REG_MISSING_CODE;
  logic [7:0] cfg_data = 8'h00;

  // Decoder state and code registers as the predictor sees them
  logic [1:0] seq_left = 2'd0;
  logic [7:0] seq_lead = 8'h00;
  logic [7:0] seq_second = 8'h00;
  logic [7:0] missing_glyph = u2l_pkg::MISSING_RESET;
  logic [7:0] invalid_glyph = u2l_pkg::INVALID_RESET;

  glyph_t pending_glyphs[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;

  utf8_to_lcd_charset_map uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Two-byte code points with a glyph
  function automatic logic [7:0] glyph_two(input logic [7:0] lead, input logic [7:0] c1);
    case (lead)
      8'hC2: begin
        case (c1)
          8'hA0: return 8'h20;
          8'hA2: return 8'hEC;
          8'hA5: return 8'h5C;
          8'hB0: return 8'hDF;
          8'hB5: return 8'hE4;
          8'hB7: return 8'hA5;
          default: return invalid_glyph;
        endcase
      end
      8'hC3: begin
        case (c1)
          8'hA4: return 8'hE1;
          8'hB1: return 8'hEE;
          8'hB6: return 8'hEF;
          8'hB7: return 8'hFD;
          8'hBC: return 8'hF5;
          default: return invalid_glyph;
        endcase
      end
      8'hCE: begin
        case (c1)
          8'hA3: return 8'hF6;
          8'hA9: return 8'hF4;
          8'hB1: return 8'hE0;
          8'hB2: return 8'hE2;
          8'hB4: return 8'hE5;
          8'hB5: return 8'hE3;
          8'hB8: return 8'hF2;
          8'hBC: return 8'hE4;
          default: return invalid_glyph;
        endcase
      end
      8'hCF: begin
        if (c1 == 8'h80) return 8'hF7;
        if (c1 == 8'h81) return 8'hE6;
        return invalid_glyph;
      end
      default: return invalid_glyph;
    endcase
  endfunction

  // Three-byte code points with a glyph; only the 0xE2 block has any
  function automatic logic [7:0] glyph_three(input logic [7:0] lead, input logic [7:0] c1,
                                             input logic [7:0] c2);
    if (lead != 8'hE2) return invalid_glyph;
    case (c1)
      8'h82: if (c2 == 8'hA4) return 8'hED;
      8'h86: begin
        if (c2 == 8'h90) return 8'h7F;
        if (c2 == 8'h92) return 8'h7E;
      end
      8'h88: begin
        if (c2 == 8'h91) return 8'hF6;
        if (c2 == 8'h9A) return 8'hE8;
        if (c2 == 8'h9E) return 8'hF3;
      end
      8'h8C: begin
        if (c2 == 8'h9C) return 8'hA2;
        if (c2 == 8'h9F) return 8'hA3;
      end
      8'h96: if (c2 == 8'h88) return 8'hFF;
      default: ;
    endcase
    return invalid_glyph;
  endfunction

  // Advance the decoder by one accepted byte and queue any code it completes
  function automatic void decode_byte(input logic [7:0] b);
    glyph_t g;
    g.is_end = 1'b0;
    if (seq_left != 2'd0) begin
      if (seq_left == 2'd2) seq_second = b;
      seq_left = seq_left - 2'd1;
      if (seq_left != 2'd0) return;
      if (seq_lead >= u2l_pkg::LEAD2_FIRST && seq_lead <= u2l_pkg::LEAD2_LAST)
        g.code = glyph_two(seq_lead, b);
      else if (seq_lead >= u2l_pkg::LEAD3_FIRST && seq_lead <= u2l_pkg::LEAD3_LAST)
        g.code = glyph_three(seq_lead, seq_second, b);
      else
        g.code = invalid_glyph;
    end else if (b == 8'h00) begin
      g.code = 8'h00;
      g.is_end = 1'b1;
    end else if (b < u2l_pkg::ASCII_FIRST) begin
      g.code = missing_glyph;
    end else if (b <= u2l_pkg::ASCII_LAST) begin
      g.code = (b == u2l_pkg::BACKSLASH) ? missing_glyph : b;
    end else if (b >= u2l_pkg::LEAD2_FIRST && b <= u2l_pkg::LEAD2_LAST) begin
      seq_lead = b;
      seq_left = 2'd1;
      return;
    end else if (b >= u2l_pkg::LEAD3_FIRST && b <= u2l_pkg::LEAD3_LAST) begin
      seq_lead = b;
      seq_left = 2'd2;
      return;
    end else if (b >= u2l_pkg::LEAD4_FIRST && b <= u2l_pkg::LEAD4_LAST) begin
      seq_lead = b;
      seq_left = 2'd3;
      return;
    end else begin
      g.code = missing_glyph;
    end
    pending_glyphs.push_back(g);
  endfunction

  // Offer one byte, idling first at random; valid stays high for a following item
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    decode_byte(b);
  endtask

  // Drop valid, wait for every expected code, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the missing code register, then the invalid code register
  task automatic write_codes(input logic [7:0] missing, input logic [7:0] invalid);
    cfg_we    <= 1'b1;
    cfg_index <= u2l_pkg::REG_MISSING_CODE;
    cfg_data  <= missing;
    @(posedge clk);
    missing_glyph = missing;
    cfg_index <= u2l_pkg::REG_INVALID_CODE;
    cfg_data  <= invalid;
    @(posedge clk);
    invalid_glyph = invalid;
    cfg_we <= 1'b0;
  endtask

  // Byte classes, lead extremes, NUL inside a sequence, mapped and unmapped sequences
  task automatic test_directed();
    logic [7:0] bytes[$];
    bytes = '{8'h00, 8'h01, 8'h1F, 8'h20, 8'h5C, 8'h7D, 8'h7E, 8'h7F, 8'h80, 8'hC1,
              8'hF5, 8'hFF, 8'hC2, 8'hA0, 8'hDF, 8'h00, 8'hE2, 8'h96, 8'h88,
              8'hEF, 8'h00, 8'hFF, 8'hF0, 8'hFF, 8'h00, 8'h80};
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Mostly well-formed text with random content, plus broken sequences and noise
  task automatic test_random_text(input int n_bytes);
    logic [15:0] two_keys[$];
    logic [23:0] three_keys[$];
    logic [15:0] k2;
    logic [23:0] k3;
    int sent;
    int pick;
    two_keys = '{16'hC2A0, 16'hC2A2, 16'hC2A5, 16'hC2B0, 16'hC2B5, 16'hC2B7, 16'hC3A4,
                 16'hC3B1, 16'hC3B6, 16'hC3B7, 16'hC3BC, 16'hCEA3, 16'hCEA9, 16'hCEB1,
                 16'hCEB2, 16'hCEB4, 16'hCEB5, 16'hCEB8, 16'hCEBC, 16'hCF80, 16'hCF81};
    three_keys = '{24'hE282A4, 24'hE28690, 24'hE28692, 24'hE28891, 24'hE2889A,
                   24'hE2889E, 24'hE28C9C, 24'hE28C9F, 24'hE29688};
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_byte(8'($urandom_range(8'h20, 8'h7F)));
        sent += 1;
      end else if (pick < 33) begin
        send_byte(8'h00);
        sent += 1;
      end else if (pick < 53) begin
        k2 = two_keys[$urandom_range(two_keys.size() - 1)];
        send_byte(k2[15:8]);
        send_byte(k2[7:0]);
        sent += 2;
      end else if (pick < 65) begin
        k3 = three_keys[$urandom_range(three_keys.size() - 1)];
        send_byte(k3[23:16]);
        send_byte(k3[15:8]);
        send_byte(k3[7:0]);
        sent += 3;
      end else if (pick < 75) begin
        send_byte(8'($urandom_range(u2l_pkg::LEAD2_FIRST, u2l_pkg::LEAD2_LAST)));
        send_byte(8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 83) begin
        send_byte(8'($urandom_range(u2l_pkg::LEAD3_FIRST, u2l_pkg::LEAD3_LAST)));
        repeat (2) send_byte(8'($urandom_range(255)));
        sent += 3;
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(u2l_pkg::LEAD4_FIRST, u2l_pkg::LEAD4_LAST)));
        repeat (3) send_byte(8'($urandom_range(255)));
        sent += 4;
      end else begin
        send_byte(8'($urandom_range(255)));
        sent += 1;
      end
    end
  endtask

  // Receiver: stall at random
  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  // Compare each accepted code with the oldest expectation
  always @(posedge clk) begin
    glyph_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_glyphs.size() == 0) begin
        $error("unexpected item: char_code %02h is_end %0b", m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_glyphs.pop_front();
        if (m_tdata !== want.code) begin
          $error("char_code: expected %02h, got %02h", want.code, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.is_end) begin
          $error("is_end: expected %0b, got %0b", want.is_end, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop on a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[utf8_to_lcd_charset_map] ERROR");
      $finish;
    end
  end

  initial begin
    src_idle_pct  = 35;
    sink_idle_pct = 52;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset codes first
    test_directed();
    wait_idle();

    write_codes(8'h00, 8'hFF);
    test_random_text(360);
    wait_idle();

    src_idle_pct  = 52;
    sink_idle_pct = 35;
    write_codes(8'hFF, 8'h00);
    test_directed();
    test_random_text(340);
    wait_idle();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_text(360);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("[utf8_to_lcd_charset_map] OK");
    end else begin
      $display("[utf8_to_lcd_charset_map] ERROR");
    end
    $finish;
  end

endmodule

/* utf8_to_lcd_charset_map.f */
rtl/u2l_pkg.sv
rtl/u2l_decode.sv
rtl/u2l_out_reg.sv
rtl/utf8_to_lcd_charset_map.sv
verif/tb_top.sv
